@@ hdl/lfu_cache_lru_tiebreak_assert.svh @@
// Assertion macros shared by the cache RTL.
// Each macro expects signals named clk and arst_n in the using module.
`ifndef LFU_CACHE_LRU_TIEBREAK_ASSERT_SVH
`define LFU_CACHE_LRU_TIEBREAK_ASSERT_SVH

// Condition must hold at every clock edge outside reset.
`define LFUC_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("lfuc: invariant violated");

// Consequent must hold in the same cycle as the antecedent.
`define LFUC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lfuc: implication violated");

// Consequent must hold in the cycle after the antecedent.
`define LFUC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lfuc: next-cycle implication violated");

`endif

@@ hdl/lfuc_pkg.sv @@
// Shared types and constants for the LFU cache with LRU tie break.
// No dependencies.
`default_nettype none

package lfuc_pkg;

	localparam int CAP_W = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
	localparam int KEY_W = 32;
	localparam int CNT_W = 16;
	localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;
	localparam logic [CNT_W-1:0] CNT_ONE = 16'd1;

	localparam logic OP_GET = 1'b0;
	localparam logic OP_SET = 1'b1;

	// Sequencer states, one-hot
	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_SCAN   = 5'b00010,
		ST_DECIDE = 5'b00100,
		ST_UPDATE = 5'b01000,
		ST_FINISH = 5'b10000
	} lfuc_state_t;

endpackage

`default_nettype wire

@@ hdl/lfuc_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module lfuc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                      clk,
	input  wire logic                                      we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                          wdata,
	input  wire logic                                      re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

@@ hdl/lfu_cache_lru_tiebreak.sv @@
// LFU key-value cache with LRU tie break: sequencer around one entry RAM.
// Depends on lfuc_pkg, lfuc_ram and lfu_cache_lru_tiebreak_assert.svh.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------------
//  config   | cfg_wr_en          | cfg_wr_data (capacity)
//  input    | in_valid/in_stall  | op, key, data_in
//  output   | out_valid/out_stall| hit, data_out, evicted, evicted_key
//
// An item that changes the store (get hit, set) takes one pass over the entry
// RAM to search and one read-modify-write pass to update ranks; one that does
// not (get miss, set with capacity zero) takes the search pass alone.
// The single RAM read port sets both pass lengths.
// Reset clears valid bits and the fill count at once; no clearing pass.
// A held result in the output register does not block the next transfer in.
`default_nettype none
`include "lfu_cache_lru_tiebreak_assert.svh"

module lfu_cache_lru_tiebreak #(
	parameter int ENTRIES = 16
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_wr_en,
	input  wire logic [lfuc_pkg::CAP_W-1:0]       cfg_wr_data,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic                             op,
	input  wire logic signed [lfuc_pkg::KEY_W-1:0] key,
	input  wire logic signed [lfuc_pkg::KEY_W-1:0] data_in,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic                                  hit,
	output logic signed [lfuc_pkg::KEY_W-1:0]     data_out,
	output logic                                  evicted,
	output logic signed [lfuc_pkg::KEY_W-1:0]     evicted_key
);

	localparam int KW   = lfuc_pkg::KEY_W;
	localparam int CW   = lfuc_pkg::CNT_W;
	localparam int IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int RW   = IW;
	localparam int CTW  = $clog2(ENTRIES + 1);
	localparam int CMPW = (lfuc_pkg::CAP_W > CTW) ? lfuc_pkg::CAP_W : CTW;
	localparam int DW   = KW + KW + CW + RW;
	localparam logic [CTW-1:0]  ENT_CT  = CTW'(ENTRIES);
	localparam logic [CMPW-1:0] ENT_CMP = CMPW'(ENTRIES);

	// control state
	lfuc_pkg::lfuc_state_t state_q;
	logic [CTW-1:0]             ctr_q;
	logic                       rd_vld_s1;
	logic [IW-1:0]              rd_idx_s1;
	logic [lfuc_pkg::CAP_W-1:0] capacity_q;
	logic [ENTRIES-1:0]         valid_q;
	logic [CTW-1:0]             used_q;
	logic                       out_valid_q;

	// item and search results
	logic          op_q;
	logic [KW-1:0] key_q;
	logic [KW-1:0] din_q;
	logic          match_found_q;
	logic [IW-1:0] match_idx_q;
	logic [KW-1:0] match_val_q;
	logic [CW-1:0] match_cnt_q;
	logic [RW-1:0] match_rank_q;
	logic          free_found_q;
	logic [IW-1:0] free_idx_q;
	logic          vic_found_q;
	logic [IW-1:0] vic_idx_q;
	logic [KW-1:0] vic_key_q;
	logic [CW-1:0] vic_cnt_q;
	logic [RW-1:0] vic_rank_q;

	// update pass target
	logic [IW-1:0] tgt_idx_q;
	logic [KW-1:0] tgt_key_q;
	logic [KW-1:0] tgt_val_q;
	logic [CW-1:0] tgt_cnt_q;
	logic [RW-1:0] lim_rank_q;
	logic          fill_all_q;

	// result waiting for the output register
	logic          res_hit_q;
	logic [KW-1:0] res_data_q;
	logic          res_evict_q;
	logic [KW-1:0] res_ekey_q;

	// output register
	logic          hit_q;
	logic [KW-1:0] data_out_q;
	logic          evicted_q;
	logic [KW-1:0] evicted_key_q;

	// RAM port signals
	logic          ram_re;
	logic          ram_we;
	logic [IW-1:0] ram_raddr;
	logic [DW-1:0] ram_wdata;
	logic [DW-1:0] ram_rdata;

	logic [KW-1:0] rd_key;
	logic [KW-1:0] rd_val;
	logic [CW-1:0] rd_cnt;
	logic [RW-1:0] rd_rank;
	logic          rd_valid;

	logic in_xfer;
	logic out_load;
	logic scan_match;
	logic vic_better;
	logic free_seen;
	logic is_tgt;
	logic shift_rank;
	logic pass_active;
	logic pass_done;

	logic [CMPW-1:0] cap_ext;
	logic [CMPW-1:0] cap_eff;
	logic [CW-1:0]   match_cnt_inc;

	// decision outcome
	logic          dec_upd;
	logic          dec_fill;
	logic [IW-1:0] dec_tgt;
	logic [KW-1:0] dec_val;
	logic [CW-1:0] dec_cnt;
	logic [RW-1:0] dec_lim;
	logic          dec_hit;
	logic [KW-1:0] dec_data;
	logic          dec_evict;
	logic [KW-1:0] dec_ekey;

	// entry RAM: {key, value, use count, recency rank}
	lfuc_ram #(
		.WIDTH (DW),
		.DEPTH (ENTRIES)
	) u_entry_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (rd_idx_s1),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// handshakes
	assign in_stall  = (state_q != lfuc_pkg::ST_IDLE);
	assign in_xfer   = in_valid && (state_q == lfuc_pkg::ST_IDLE);
	assign out_load  = (state_q == lfuc_pkg::ST_FINISH) && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign hit         = hit_q;
	assign data_out    = data_out_q;
	assign evicted     = evicted_q;
	assign evicted_key = evicted_key_q;

	// RAM read sweep, shared by both passes
	assign pass_active = (state_q == lfuc_pkg::ST_SCAN) || (state_q == lfuc_pkg::ST_UPDATE);
	assign pass_done   = (ctr_q == ENT_CT);
	assign ram_re      = pass_active && !pass_done;
	assign ram_raddr   = ctr_q[IW-1:0];

	// read data fields
	assign rd_key   = ram_rdata[DW-1 -: KW];
	assign rd_val   = ram_rdata[DW-KW-1 -: KW];
	assign rd_cnt   = ram_rdata[RW+CW-1 -: CW];
	assign rd_rank  = ram_rdata[RW-1:0];
	assign rd_valid = valid_q[rd_idx_s1];

	// search step
	assign scan_match = rd_vld_s1 && rd_valid && (rd_key == key_q);
	assign free_seen  = rd_vld_s1 && !rd_valid;
	assign vic_better = rd_vld_s1 && rd_valid &&
		(!vic_found_q || (rd_cnt < vic_cnt_q) ||
		 ((rd_cnt == vic_cnt_q) && (rd_rank > vic_rank_q)));

	// update step: target gets new contents, newer entries age by one
	assign is_tgt     = (rd_idx_s1 == tgt_idx_q);
	assign shift_rank = rd_valid && (fill_all_q || (rd_rank < lim_rank_q));
	assign ram_we     = (state_q == lfuc_pkg::ST_UPDATE) && rd_vld_s1 && (is_tgt || shift_rank);
	assign ram_wdata  = is_tgt ? {tgt_key_q, tgt_val_q, tgt_cnt_q, RW'(0)}
	                           : {rd_key, rd_val, rd_cnt, rd_rank + RW'(1)};

	// effective capacity, clamped to the entry count
	assign cap_ext       = CMPW'(capacity_q);
	assign cap_eff       = (cap_ext > ENT_CMP) ? ENT_CMP : cap_ext;
	assign match_cnt_inc = (match_cnt_q == lfuc_pkg::CNT_MAX) ? match_cnt_q
	                                                           : match_cnt_q + CW'(1);

	// decide hit, fill or eviction from the search results
	always_comb begin
		dec_upd   = 1'b0;
		dec_fill  = 1'b0;
		dec_tgt   = match_idx_q;
		dec_val   = match_val_q;
		dec_cnt   = match_cnt_inc;
		dec_lim   = match_rank_q;
		dec_hit   = 1'b0;
		dec_data  = '0;
		dec_evict = 1'b0;
		dec_ekey  = '0;
		if (op_q == lfuc_pkg::OP_GET) begin
			if (match_found_q) begin
				dec_upd  = 1'b1;
				dec_hit  = 1'b1;
				dec_data = match_val_q;
			end
		end else if (cap_eff != '0) begin
			if (match_found_q) begin
				dec_upd = 1'b1;
				dec_hit = 1'b1;
				dec_val = din_q;
			end else if (CMPW'(used_q) < cap_eff) begin
				dec_upd  = 1'b1;
				dec_fill = 1'b1;
				dec_tgt  = free_idx_q;
				dec_val  = din_q;
				dec_cnt  = lfuc_pkg::CNT_ONE;
			end else begin
				dec_upd   = 1'b1;
				dec_tgt   = vic_idx_q;
				dec_val   = din_q;
				dec_cnt   = lfuc_pkg::CNT_ONE;
				dec_lim   = vic_rank_q;
				dec_evict = 1'b1;
				dec_ekey  = vic_key_q;
			end
		end
	end

	// sequencer and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= lfuc_pkg::ST_IDLE;
			ctr_q         <= '0;
			rd_vld_s1     <= 1'b0;
			capacity_q    <= lfuc_pkg::CAP_RESET;
			valid_q       <= '0;
			used_q        <= '0;
			out_valid_q   <= 1'b0;
			match_found_q <= 1'b0;
			free_found_q  <= 1'b0;
			vic_found_q   <= 1'b0;
			fill_all_q    <= 1'b0;
		end else begin
			rd_vld_s1 <= ram_re;
			if (cfg_wr_en) begin
				capacity_q <= cfg_wr_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				lfuc_pkg::ST_IDLE: begin
					if (in_xfer) begin
						state_q       <= lfuc_pkg::ST_SCAN;
						ctr_q         <= '0;
						match_found_q <= 1'b0;
						free_found_q  <= 1'b0;
						vic_found_q   <= 1'b0;
					end
				end
				lfuc_pkg::ST_SCAN: begin
					if (scan_match) begin
						match_found_q <= 1'b1;
					end
					if (free_seen) begin
						free_found_q <= 1'b1;
					end
					if (vic_better) begin
						vic_found_q <= 1'b1;
					end
					if (pass_done) begin
						state_q <= lfuc_pkg::ST_DECIDE;
					end else begin
						ctr_q <= ctr_q + CTW'(1);
					end
				end
				lfuc_pkg::ST_DECIDE: begin
					ctr_q      <= '0;
					fill_all_q <= dec_fill;
					if (dec_fill) begin
						valid_q[dec_tgt] <= 1'b1;
						used_q           <= used_q + CTW'(1);
					end
					state_q <= dec_upd ? lfuc_pkg::ST_UPDATE : lfuc_pkg::ST_FINISH;
				end
				lfuc_pkg::ST_UPDATE: begin
					if (pass_done) begin
						state_q <= lfuc_pkg::ST_FINISH;
					end else begin
						ctr_q <= ctr_q + CTW'(1);
					end
				end
				lfuc_pkg::ST_FINISH: begin
					if (out_load) begin
						state_q <= lfuc_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= lfuc_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		rd_idx_s1 <= ctr_q[IW-1:0];
		if (in_xfer) begin
			op_q  <= op;
			key_q <= key;
			din_q <= data_in;
		end
		// search accumulators: first match, first free slot, best victim
		if (state_q == lfuc_pkg::ST_SCAN) begin
			if (scan_match && !match_found_q) begin
				match_idx_q  <= rd_idx_s1;
				match_val_q  <= rd_val;
				match_cnt_q  <= rd_cnt;
				match_rank_q <= rd_rank;
			end
			if (free_seen && !free_found_q) begin
				free_idx_q <= rd_idx_s1;
			end
			if (vic_better) begin
				vic_idx_q  <= rd_idx_s1;
				vic_key_q  <= rd_key;
				vic_cnt_q  <= rd_cnt;
				vic_rank_q <= rd_rank;
			end
		end
		if (state_q == lfuc_pkg::ST_DECIDE) begin
			tgt_idx_q   <= dec_tgt;
			tgt_key_q   <= key_q;
			tgt_val_q   <= dec_val;
			tgt_cnt_q   <= dec_cnt;
			lim_rank_q  <= dec_lim;
			res_hit_q   <= dec_hit;
			res_data_q  <= dec_data;
			res_evict_q <= dec_evict;
			res_ekey_q  <= dec_ekey;
		end
		if (out_load) begin
			hit_q         <= res_hit_q;
			data_out_q    <= res_data_q;
			evicted_q     <= res_evict_q;
			evicted_key_q <= res_ekey_q;
		end
	end

	// checks
	`LFUC_ASSERT_ALWAYS(a_used_matches_valid, $countones(valid_q) == int'(used_q))
	`LFUC_ASSERT_IMP(a_write_only_in_update, ram_we, state_q == lfuc_pkg::ST_UPDATE)
	`LFUC_ASSERT_IMP(a_fill_has_free_slot, (state_q == lfuc_pkg::ST_DECIDE) && dec_fill, free_found_q && !valid_q[free_idx_q])
	`LFUC_ASSERT_IMP(a_hit_excludes_evict, out_valid_q, !(hit_q && evicted_q))
	`LFUC_ASSERT_NXT(a_load_returns_idle, out_load, (state_q == lfuc_pkg::ST_IDLE) && out_valid_q)

endmodule

`default_nettype wire

@@ tb/sv/lfu_cache_lru_tiebreak_test.sv @@
// Self-checking testbench for the LFU cache with LRU tie break.
// Holds a shadow copy of the cache, drives gets and sets under several capacities.
// Depends on lfuc_pkg and the lfu_cache_lru_tiebreak RTL.

module lfu_cache_lru_tiebreak_test;

	localparam int ENTRY_COUNT = 16;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int ITEMS_PER_PHASE = 168;
	localparam int POOL_SIZE = 24;
	localparam int PRINT_CAP = 60;

	// Shadow of the cache contents; predicts one result per accepted transfer
	class lfu_mirror;
		localparam int SLOTS = ENTRY_COUNT;

		typedef struct packed {
			logic                         hit;
			logic [lfuc_pkg::KEY_W-1:0] data_out;
			logic                         evicted;
			logic [lfuc_pkg::KEY_W-1:0] evicted_key;
		} cache_resp_t;

		bit                           vld[SLOTS];
		logic [lfuc_pkg::KEY_W-1:0] slot_key[SLOTS];
		logic [lfuc_pkg::KEY_W-1:0] slot_val[SLOTS];
		logic [lfuc_pkg::CNT_W-1:0] uses[SLOTS];
		logic [3:0]                   rank[SLOTS];
		int                           used;
		logic [lfuc_pkg::CAP_W-1:0] capacity;
		cache_resp_t                  pending_resp[$];
		int                           errors;

		function new();
			foreach (vld[i]) vld[i] = 1'b0;
			used = 0;
			capacity = lfuc_pkg::CAP_RESET;
			errors = 0;
		endfunction

		task report(string what);
			errors++;
			if (errors <= PRINT_CAP)
				$display("%0t: mismatch: %s", $time, what);
		endtask

		// Slot s becomes most recent; valid slots ranked below lim move back one
		function void promote(int s, int lim);
			for (int i = 0; i < SLOTS; i++)
				if (vld[i] && i != s && int'(rank[i]) < lim)
					rank[i]++;
			rank[s] = '0;
		endfunction

		function void touch(int s);
			if (uses[s] != lfuc_pkg::CNT_MAX)
				uses[s]++;
			promote(s, int'(rank[s]));
		endfunction

		function int lookup(logic [lfuc_pkg::KEY_W-1:0] k);
			for (int i = 0; i < SLOTS; i++)
				if (vld[i] && slot_key[i] == k)
					return i;
			return -1;
		endfunction

		function cache_resp_t predict_item(logic o, logic [lfuc_pkg::KEY_W-1:0] k,
				logic [lfuc_pkg::KEY_W-1:0] d);
			cache_resp_t r;
			int eff_cap;
			int s;
			int victim;
			r = '0;
			eff_cap = (int'(capacity) > SLOTS) ? SLOTS : int'(capacity);
			s = lookup(k);
			if (o == lfuc_pkg::OP_GET) begin
				if (s >= 0) begin
					r.hit = 1'b1;
					r.data_out = slot_val[s];
					touch(s);
				end
				return r;
			end
			// capacity zero: a set does nothing at all, even on a present key
			if (eff_cap == 0)
				return r;
			if (s >= 0) begin
				r.hit = 1'b1;
				slot_val[s] = d;
				touch(s);
				return r;
			end
			if (used < eff_cap) begin
				s = 0;
				while (vld[s])
					s++;
				promote(s, SLOTS + 1);
				vld[s] = 1'b1;
				used++;
			end else begin
				// lowest count wins; among equals the least recent (highest rank)
				victim = -1;
				for (int i = 0; i < SLOTS; i++) begin
					if (!vld[i])
						continue;
					if (victim < 0 || uses[i] < uses[victim] ||
							(uses[i] == uses[victim] && rank[i] > rank[victim]))
						victim = i;
				end
				s = victim;
				r.evicted = 1'b1;
				r.evicted_key = slot_key[s];
				promote(s, int'(rank[s]));
			end
			slot_key[s] = k;
			slot_val[s] = d;
			uses[s] = lfuc_pkg::CNT_ONE;
			return r;
		endfunction

		function void accept_item(logic o, logic [lfuc_pkg::KEY_W-1:0] k,
				logic [lfuc_pkg::KEY_W-1:0] d);
			pending_resp.push_back(predict_item(o, k, d));
		endfunction

		task check_result(logic h, logic [lfuc_pkg::KEY_W-1:0] d, logic e,
				logic [lfuc_pkg::KEY_W-1:0] ek);
			cache_resp_t x;
			if (pending_resp.size() == 0) begin
				report("result transfer with nothing outstanding");
				return;
			end
			x = pending_resp.pop_front();
			if (h !== x.hit)
				report($sformatf("hit got %b exp %b", h, x.hit));
			if (d !== x.data_out)
				report($sformatf("data_out got %h exp %h", d, x.data_out));
			if (e !== x.evicted)
				report($sformatf("evicted got %b exp %b", e, x.evicted));
			if (ek !== x.evicted_key)
				report($sformatf("evicted_key got %h exp %h", ek, x.evicted_key));
		endtask
	endclass

	logic                              clk;
	logic                              arst_n;
	logic                              cfg_wr_en;
	logic [lfuc_pkg::CAP_W-1:0]        cfg_wr_data;
	logic                              in_valid;
	logic                              in_stall;
	logic                              op;
	logic signed [lfuc_pkg::KEY_W-1:0] key;
	logic signed [lfuc_pkg::KEY_W-1:0] data_in;
	logic                              out_valid;
	logic                              out_stall;
	logic                              hit;
	logic signed [lfuc_pkg::KEY_W-1:0] data_out;
	logic                              evicted;
	logic signed [lfuc_pkg::KEY_W-1:0] evicted_key;

	lfu_mirror mirror;

	int                         send_idle_pct;
	int                         recv_stall_pct;
	int                         cycle_count;
	logic [lfuc_pkg::KEY_W-1:0] key_pool[POOL_SIZE];

	lfu_cache_lru_tiebreak #(
		.ENTRIES(ENTRY_COUNT)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.key(key),
		.data_in(data_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.hit(hit),
		.data_out(data_out),
		.evicted(evicted),
		.evicted_key(evicted_key)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit roll(int pct);
		return $urandom_range(99, 0) < pct;
	endfunction

	// Receiver: random stall at the falling edge, result check at the rising edge
	always @(negedge clk) begin
		out_stall = arst_n ? roll(recv_stall_pct) : 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			mirror.check_result(hit, data_out, evicted, evicted_key);
	end

	// Watchdog
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("lfu_cache_lru_tiebreak_test NOT OK");
		$finish;
	end

	// One input transfer; called and returns at a falling edge
	task automatic push_item(logic o, logic [lfuc_pkg::KEY_W-1:0] k,
			logic [lfuc_pkg::KEY_W-1:0] d);
		while (roll(send_idle_pct)) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		op = o;
		key = k;
		data_in = d;
		do
			@(posedge clk);
		while (in_stall);
		mirror.accept_item(o, k, d);
		@(negedge clk);
	endtask

	// Capacity write once all results are back and the block takes input again
	task automatic write_capacity(logic [lfuc_pkg::CAP_W-1:0] c);
		in_valid = 1'b0;
		while (mirror.pending_resp.size() != 0 || in_stall)
			@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_wr_data = c;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		mirror.capacity = c;
	endtask

	task automatic run_directed();
		push_item(lfuc_pkg::OP_GET, 32'h0000_0000, 32'h1111_1111);
		push_item(lfuc_pkg::OP_SET, 32'h8000_0000, 32'h7FFF_FFFF);
		push_item(lfuc_pkg::OP_SET, 32'h7FFF_FFFF, 32'h8000_0000);
		push_item(lfuc_pkg::OP_SET, 32'h0000_0000, 32'h0000_0000);
		push_item(lfuc_pkg::OP_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_item(lfuc_pkg::OP_GET, 32'h8000_0000, 32'h0);
		push_item(lfuc_pkg::OP_GET, 32'h7FFF_FFFF, 32'h0);
		push_item(lfuc_pkg::OP_GET, 32'hFFFF_FFFF, 32'h0);
		push_item(lfuc_pkg::OP_SET, 32'h0000_0000, 32'hA5A5_A5A5);
		push_item(lfuc_pkg::OP_GET, 32'h0000_0000, 32'h0);
		push_item(lfuc_pkg::OP_GET, 32'h1234_5678, 32'h0);
		// capacity zero: sets are dropped, stored keys still answer gets
		write_capacity(5'd0);
		push_item(lfuc_pkg::OP_SET, 32'h5555_5555, 32'h0000_0001);
		push_item(lfuc_pkg::OP_SET, 32'h0000_0000, 32'h0000_0002);
		push_item(lfuc_pkg::OP_GET, 32'h0000_0000, 32'h0);
		// capacity below the fill count: each miss replaces an entry
		write_capacity(5'd1);
		push_item(lfuc_pkg::OP_SET, 32'h0F0F_0F0F, 32'h0000_0003);
		push_item(lfuc_pkg::OP_SET, 32'h3333_3333, 32'h0000_0004);
		push_item(lfuc_pkg::OP_GET, 32'h3333_3333, 32'h0);
		push_item(lfuc_pkg::OP_GET, 32'h0F0F_0F0F, 32'h0);
		// capacity above the slot count acts as full size
		write_capacity(5'd31);
		push_item(lfuc_pkg::OP_SET, 32'hCCCC_CCCC, 32'hF0F0_F0F0);
		push_item(lfuc_pkg::OP_SET, 32'h0000_0001, 32'h0F0F_0F0F);
		push_item(lfuc_pkg::OP_GET, 32'hCCCC_CCCC, 32'h0);
	endtask

	// Random gets and sets mostly over a key pool slightly larger than capacity
	task automatic run_phase(int cap, int idle_pct, int stall_pct);
		int eff_cap;
		int pool_n;
		logic [lfuc_pkg::KEY_W-1:0] k;
		write_capacity(cap[lfuc_pkg::CAP_W-1:0]);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		for (int i = 0; i < 6; i++)
			key_pool[$urandom_range(POOL_SIZE - 1, 4)] = $urandom;
		eff_cap = (cap > ENTRY_COUNT) ? ENTRY_COUNT : cap;
		pool_n = (eff_cap == 0) ? 8 : eff_cap + $urandom_range(6, 1);
		if (pool_n > POOL_SIZE)
			pool_n = POOL_SIZE;
		for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
			k = roll(85) ? key_pool[$urandom_range(pool_n - 1, 0)] : $urandom;
			push_item(roll(50) ? lfuc_pkg::OP_SET : lfuc_pkg::OP_GET, k, $urandom);
		end
	endtask

	initial begin
		int caps[8];
		mirror = new();
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		op = lfuc_pkg::OP_GET;
		key = '0;
		data_in = '0;
		out_stall = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		key_pool[0] = 32'h8000_0000;
		key_pool[1] = 32'h7FFF_FFFF;
		key_pool[2] = 32'h0000_0000;
		key_pool[3] = 32'hFFFF_FFFF;
		for (int i = 4; i < POOL_SIZE; i++)
			key_pool[i] = $urandom;
		caps = '{16, 3, 31, 0, 1, 8, 17, $urandom_range(31, 0)};
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		run_directed();
		// idle profiles in turn: none, sender, receiver, both
		for (int p = 0; p < 8; p++) begin
			case (p % 4)
				0: run_phase(caps[p], 0, 0);
				1: run_phase(caps[p], 78, 0);
				2: run_phase(caps[p], 0, 78);
				default: run_phase(caps[p], 26, 26);
			endcase
		end
		in_valid = 1'b0;

		// Drain, then watch a while for stray results
		while (mirror.pending_resp.size() != 0)
			@(posedge clk);
		repeat (2 * ENTRY_COUNT + 8) @(posedge clk);
		if (mirror.errors == 0)
			$display("lfu_cache_lru_tiebreak_test OK");
		else
			$display("lfu_cache_lru_tiebreak_test NOT OK");
		$finish;
	end

endmodule
